// ===== hw/rtl/tfp_pkg.sv =====
package tfp_pkg;

   localparam int PAYLOAD_MAX_DEFAULT = 32;
   localparam int KEPT_BYTES          = 8;
   localparam int BYTE_W              = 8;
   localparam int WORD_W              = 16;
   localparam int KIND_W              = 2;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 16;

   localparam logic [BYTE_W-1:0] FIRST_START_RESET  = 8'h5A;
   localparam logic [BYTE_W-1:0] SECOND_START_RESET = 8'hA5;
   localparam logic [WORD_W-1:0] SCREEN_ADDR_RESET  = 16'h0084;
   localparam logic [WORD_W-1:0] KEY_LOW_RESET      = 16'h1000;
   localparam logic [WORD_W-1:0] KEY_HIGH_RESET     = 16'hFFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_START  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_START = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_ADDR  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH     = 3'd4;

   typedef enum logic [1:0] {
      PHASE_HUNT1   = 2'd0,
      PHASE_HUNT2   = 2'd1,
      PHASE_LENGTH  = 2'd2,
      PHASE_PAYLOAD = 2'd3
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SCREEN  = 2'd0,
      KIND_KEY     = 2'd1,
      KIND_IGNORED = 2'd2
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] first_start;
      logic [BYTE_W-1:0] second_start;
      logic [WORD_W-1:0] screen_addr;
      logic [WORD_W-1:0] key_low;
      logic [WORD_W-1:0] key_high;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] address;
      logic [WORD_W-1:0] value;
      kind_type          kind;
   } result_type;

endpackage

// ===== hw/rtl/tfp_channels.sv =====
interface tfp_byte_if;
   logic                          valid;
   logic                          ready;
   logic [tfp_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_frame_if;
   logic                          valid;
   logic                          ready;
   logic [tfp_pkg::WORD_W-1:0]    frame_address;
   logic [tfp_pkg::WORD_W-1:0]    frame_value;
   logic [tfp_pkg::KIND_W-1:0]    frame_kind;

   modport source (output valid, output frame_address, output frame_value,
                   output frame_kind, input ready);
   modport sink   (input valid, input frame_address, input frame_value,
                   input frame_kind, output ready);
endinterface

// ===== hw/rtl/tfp_csr_regs.sv =====
module tfp_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tfp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tfp_pkg::cfg_type                    cfg
);

   tfp_pkg::cfg_type cfg_ff;
   tfp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tfp_pkg::CSR_FIRST_START:  cfg_in.first_start  = csr_wdata[tfp_pkg::BYTE_W-1:0];
            tfp_pkg::CSR_SECOND_START: cfg_in.second_start = csr_wdata[tfp_pkg::BYTE_W-1:0];
            tfp_pkg::CSR_SCREEN_ADDR:  cfg_in.screen_addr  = csr_wdata;
            tfp_pkg::CSR_KEY_LOW:      cfg_in.key_low      = csr_wdata;
            tfp_pkg::CSR_KEY_HIGH:     cfg_in.key_high     = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_start  <= tfp_pkg::FIRST_START_RESET;
         cfg_ff.second_start <= tfp_pkg::SECOND_START_RESET;
         cfg_ff.screen_addr  <= tfp_pkg::SCREEN_ADDR_RESET;
         cfg_ff.key_low      <= tfp_pkg::KEY_LOW_RESET;
         cfg_ff.key_high     <= tfp_pkg::KEY_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/tfp_in_stage.sv =====
module tfp_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   tfp_byte_if.sink                     req_if,
   input  logic                         take,
   output logic                         byte_valid,
   output logic [tfp_pkg::BYTE_W-1:0]   byte_data
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [tfp_pkg::BYTE_W-1:0]  data_ff;
   logic [tfp_pkg::BYTE_W-1:0]  data_in;
   logic                        accept;

   assign req_if.ready = !valid_ff || take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_if.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ===== hw/rtl/tfp_parser.sv =====
module tfp_parser #(
   parameter int PAYLOAD_MAX = tfp_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tfp_pkg::cfg_type             cfg,
   input  logic                         byte_valid,
   input  logic [tfp_pkg::BYTE_W-1:0]   byte_data,
   input  logic                         out_room,
   output logic                         take,
   output logic                         res_load,
   output tfp_pkg::result_type          res
);

   localparam int CNT_W = $clog2(PAYLOAD_MAX);

   tfp_pkg::phase_type          phase_ff;
   tfp_pkg::phase_type          phase_in;
   logic [CNT_W-1:0]            expected_ff;
   logic [CNT_W-1:0]            expected_in;
   logic [CNT_W-1:0]            received_ff;
   logic [CNT_W-1:0]            received_in;
   logic [tfp_pkg::BYTE_W-1:0]  cap_ff [tfp_pkg::KEPT_BYTES];
   logic [tfp_pkg::BYTE_W-1:0]  cap_in [tfp_pkg::KEPT_BYTES];
   logic [tfp_pkg::BYTE_W-1:0]  view   [tfp_pkg::KEPT_BYTES];

   logic [CNT_W-1:0]            count_next;
   logic                        len_ok;
   logic                        done;
   logic [tfp_pkg::WORD_W-1:0]  addr;

   assign count_next = received_ff + CNT_W'(1);
   assign len_ok     = (byte_data != '0) &&
                       ({1'b0, byte_data} < (tfp_pkg::BYTE_W + 1)'(PAYLOAD_MAX));
   assign done       = (phase_ff == tfp_pkg::PHASE_PAYLOAD) && (count_next >= expected_ff);
   assign take       = byte_valid && (!done || out_room);

   // next state
   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      if (take) begin
         case (phase_ff)
            tfp_pkg::PHASE_HUNT1: begin
               if (byte_data == cfg.first_start) phase_in = tfp_pkg::PHASE_HUNT2;
            end
            tfp_pkg::PHASE_HUNT2: begin
               if (byte_data == cfg.second_start) begin
                  phase_in = tfp_pkg::PHASE_LENGTH;
               end else begin
                  phase_in    = tfp_pkg::PHASE_HUNT1;
                  expected_in = '0;
                  received_in = '0;
               end
            end
            tfp_pkg::PHASE_LENGTH: begin
               if (len_ok) begin
                  phase_in    = tfp_pkg::PHASE_PAYLOAD;
                  expected_in = byte_data[CNT_W-1:0];
               end else begin
                  phase_in    = tfp_pkg::PHASE_HUNT1;
                  expected_in = '0;
                  received_in = '0;
               end
            end
            tfp_pkg::PHASE_PAYLOAD: begin
               if (done) begin
                  phase_in    = tfp_pkg::PHASE_HUNT1;
                  expected_in = '0;
                  received_in = '0;
               end else begin
                  received_in = count_next;
               end
            end
            default: phase_in = tfp_pkg::PHASE_HUNT1;
         endcase
      end
   end

   // payload capture; bytes past the current count read as zero
   always_comb begin
      for (int i = 0; i < tfp_pkg::KEPT_BYTES; i++) begin
         cap_in[i] = cap_ff[i];
         if (take && (phase_ff == tfp_pkg::PHASE_PAYLOAD) && (received_ff == CNT_W'(i)))
            cap_in[i] = byte_data;
         if (CNT_W'(i) >= count_next)
            view[i] = '0;
         else if (received_ff == CNT_W'(i))
            view[i] = byte_data;
         else
            view[i] = cap_ff[i];
      end
   end

   // outputs
   always_comb begin
      addr        = {view[1], view[2]};
      res.address = addr;
      if (addr == cfg.screen_addr) begin
         res.value = {view[6], view[7]};
         res.kind  = tfp_pkg::KIND_SCREEN;
      end else begin
         res.value = {view[4], view[5]};
         if ((addr >= cfg.key_low) && (addr <= cfg.key_high))
            res.kind = tfp_pkg::KIND_KEY;
         else
            res.kind = tfp_pkg::KIND_IGNORED;
      end
      res_load = take && done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= tfp_pkg::PHASE_HUNT1;
         expected_ff <= '0;
         received_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
   end

endmodule

// ===== hw/rtl/tfp_out_stage.sv =====
module tfp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_load,
   input  tfp_pkg::result_type   res,
   output logic                  out_room,
   tfp_frame_if.source           rsp_if
);

   logic                  valid_ff;
   logic                  valid_in;
   tfp_pkg::result_type   data_ff;
   tfp_pkg::result_type   data_in;

   assign out_room = !valid_ff || rsp_if.ready;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff && !rsp_if.ready;
      if (res_load) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.frame_address = data_ff.address;
   assign rsp_if.frame_value   = data_ff.value;
   assign rsp_if.frame_kind    = data_ff.kind;

endmodule

// ===== hw/rtl/touch_frame_parser_core.sv =====
// Result: the output register loads a frame's result word at the edge where the parser takes its last byte.
// Throughput: one byte word per cycle; the input register frees whenever the
// parser takes its byte, which stalls only for a frame-ending byte while the
// result register is full and not being drained.
// Reset: synchronous, active high; parser hunts for the first start byte, both
// stages empty, configuration registers back to their default values. No clearing pass.
module touch_frame_parser_core #(
   parameter int PAYLOAD_MAX = tfp_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   tfp_byte_if.sink                            req_if,
   tfp_frame_if.source                         rsp_if,
   input  logic                                csr_wr_en,
   input  logic [tfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tfp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tfp_pkg::cfg_type            cfg;
   tfp_pkg::result_type         res;
   logic                        byte_valid;
   logic [tfp_pkg::BYTE_W-1:0]  byte_data;
   logic                        take;
   logic                        res_load;
   logic                        out_room;

   tfp_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   tfp_parser #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_room   (out_room),
      .take       (take),
      .res_load   (res_load),
      .res        (res)
   );

   tfp_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .res_load (res_load),
      .res      (res),
      .out_room (out_room),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== hw/rtl/tfp_checker.sv =====
module tfp_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [tfp_pkg::WORD_W-1:0]   rsp_address,
   input  logic [tfp_pkg::WORD_W-1:0]   rsp_value,
   input  logic [tfp_pkg::KIND_W-1:0]   rsp_kind
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_address) && $stable(rsp_value) && $stable(rsp_kind))
      else $error("result word changed while stalled");

   a_reset_empty_out: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_reset_ready_in: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("input not ready right after reset");

endmodule

bind touch_frame_parser_core tfp_checker u_tfp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_address (rsp_if.frame_address),
   .rsp_value   (rsp_if.frame_value),
   .rsp_kind    (rsp_if.frame_kind)
);

// ===== bench/touch_frame_parser_core_tb.sv =====
`timescale 1ns / 1ps

module touch_frame_parser_core_tb;

   localparam int PAYLOAD_MAX = tfp_pkg::PAYLOAD_MAX_DEFAULT;

   class frame_ledger;
      tfp_pkg::cfg_type                cfg;
      tfp_pkg::phase_type              phase;
      logic [tfp_pkg::BYTE_W-1:0]      length_byte;
      logic [tfp_pkg::BYTE_W-1:0]      taken;
      logic [tfp_pkg::BYTE_W-1:0]      kept [tfp_pkg::KEPT_BYTES];
      tfp_pkg::result_type             pending_frames [$];
      int                              errors;
      int                              matched;

      function new();
         cfg.first_start  = tfp_pkg::FIRST_START_RESET;
         cfg.second_start = tfp_pkg::SECOND_START_RESET;
         cfg.screen_addr  = tfp_pkg::SCREEN_ADDR_RESET;
         cfg.key_low      = tfp_pkg::KEY_LOW_RESET;
         cfg.key_high     = tfp_pkg::KEY_HIGH_RESET;
         errors  = 0;
         matched = 0;
         restart();
      endfunction

      function void restart();
         foreach (kept[i]) kept[i] = '0;
         taken       = '0;
         length_byte = '0;
         phase       = tfp_pkg::PHASE_HUNT1;
      endfunction

      function int pending();
         return pending_frames.size();
      endfunction

      function void take_byte(logic [tfp_pkg::BYTE_W-1:0] b);
         tfp_pkg::result_type        r;
         logic [tfp_pkg::WORD_W-1:0] a;
         case (phase)
            tfp_pkg::PHASE_HUNT1: begin
               if (b == cfg.first_start) phase = tfp_pkg::PHASE_HUNT2;
            end
            tfp_pkg::PHASE_HUNT2: begin
               if (b == cfg.second_start) phase = tfp_pkg::PHASE_LENGTH;
               else restart();
            end
            tfp_pkg::PHASE_LENGTH: begin
               if (b != 0 && int'(b) < PAYLOAD_MAX) begin
                  length_byte = b;
                  phase       = tfp_pkg::PHASE_PAYLOAD;
               end else begin
                  restart();
               end
            end
            default: begin
               if (int'(taken) < PAYLOAD_MAX && taken != 8'hFF) begin
                  if (int'(taken) < tfp_pkg::KEPT_BYTES) kept[taken[2:0]] = b;
                  taken = taken + 8'd1;
               end
               if (taken >= length_byte) begin
                  a = {kept[1], kept[2]};
                  r.address = a;
                  if (a == cfg.screen_addr) begin
                     r.value = {kept[6], kept[7]};
                     r.kind  = tfp_pkg::KIND_SCREEN;
                  end else begin
                     r.value = {kept[4], kept[5]};
                     r.kind  = (a >= cfg.key_low && a <= cfg.key_high) ?
                               tfp_pkg::KIND_KEY : tfp_pkg::KIND_IGNORED;
                  end
                  pending_frames.push_back(r);
                  restart();
               end
            end
         endcase
      endfunction

      function void match_frame(logic [tfp_pkg::WORD_W-1:0] a, logic [tfp_pkg::WORD_W-1:0] v,
                                logic [tfp_pkg::KIND_W-1:0] k);
         tfp_pkg::result_type r;
         if (pending_frames.size() == 0) begin
            $error("unexpected frame word: address %h value %h kind %0d", a, v, k);
            errors++;
            return;
         end
         r = pending_frames.pop_front();
         matched++;
         if (a !== r.address) begin
            $error("frame_address: expected %h, actual %h", r.address, a);
            errors++;
         end
         if (v !== r.value) begin
            $error("frame_value: expected %h, actual %h", r.value, v);
            errors++;
         end
         if (k !== r.kind) begin
            $error("frame_kind: expected %0d, actual %0d", r.kind, k);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [tfp_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [tfp_pkg::CSR_DATA_W-1:0]   csr_wdata;

   tfp_byte_if  req_ch ();
   tfp_frame_if rsp_ch ();

   touch_frame_parser_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_ledger ledger;
   int          src_idle;
   int          sink_idle;
   int          bytes_sent;
   int          settings_used;

   // start mismatch, bad lengths, short payload, full screen report
   logic [tfp_pkg::BYTE_W-1:0] directed_seq [$] = '{
      8'h5A, 8'hA5, 8'h08, 8'h00, 8'h00, 8'h84, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55,
      8'h5A, 8'h5A, 8'hA5,
      8'h5A, 8'hA5, 8'h00,
      8'h5A, 8'hA5, 8'h20,
      8'h5A, 8'hA5, 8'h03, 8'hFF, 8'hFF, 8'hFF
   };

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ledger.match_frame(rsp_ch.frame_address, rsp_ch.frame_value, rsp_ch.frame_kind);
   end

   task automatic send_byte(input logic [tfp_pkg::BYTE_W-1:0] b);
      if (src_idle != 0 && $urandom_range(99) < src_idle) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      ledger.take_byte(b);
      bytes_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [tfp_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [tfp_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_cfg(input tfp_pkg::cfg_type c);
      csr_put(tfp_pkg::CSR_FIRST_START,  {8'h00, c.first_start});
      csr_put(tfp_pkg::CSR_SECOND_START, {8'h00, c.second_start});
      csr_put(tfp_pkg::CSR_SCREEN_ADDR,  c.screen_addr);
      csr_put(tfp_pkg::CSR_KEY_LOW,      c.key_low);
      csr_put(tfp_pkg::CSR_KEY_HIGH,     c.key_high);
      csr_wr_en <= 1'b0;
      ledger.cfg = c;
      settings_used++;
   endtask

   function automatic tfp_pkg::cfg_type make_cfg(int p);
      tfp_pkg::cfg_type c;
      c.first_start  = tfp_pkg::FIRST_START_RESET;
      c.second_start = tfp_pkg::SECOND_START_RESET;
      c.screen_addr  = tfp_pkg::SCREEN_ADDR_RESET;
      c.key_low      = tfp_pkg::KEY_LOW_RESET;
      c.key_high     = tfp_pkg::KEY_HIGH_RESET;
      case (p)
         1: begin
            c.first_start  = 8'h00;
            c.second_start = 8'hFF;
            c.screen_addr  = 16'h0000;
            c.key_low      = 16'h0000;
            c.key_high     = 16'hFFFF;
         end
         2: begin
            // inverted window
            c.first_start  = 8'hFF;
            c.second_start = 8'h00;
            c.screen_addr  = 16'hFFFF;
            c.key_low      = 16'h8000;
            c.key_high     = 16'h7FFF;
         end
         3: begin
            c.first_start  = 8'($urandom);
            c.second_start = 8'($urandom);
            c.screen_addr  = 16'($urandom);
            c.key_low      = 16'($urandom);
            c.key_high     = c.key_low;
         end
         4: begin
            c.first_start  = 8'($urandom);
            c.second_start = c.first_start;
            c.screen_addr  = 16'($urandom);
            c.key_low      = 16'($urandom);
            c.key_high     = c.key_low + 16'($urandom_range(255));
         end
         5: begin
            c.first_start  = 8'($urandom);
            c.second_start = 8'($urandom);
            c.screen_addr  = 16'($urandom);
            c.key_low      = 16'($urandom);
            c.key_high     = 16'($urandom);
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic send_frame();
      int                         len;
      int                         pick;
      logic [tfp_pkg::WORD_W-1:0] a;
      logic [tfp_pkg::BYTE_W-1:0] b;
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, PAYLOAD_MAX - 1);
      else if (pick < 97) len = 0;
      else                len = $urandom_range(PAYLOAD_MAX, 255);
      case ($urandom_range(5))
         0:       a = ledger.cfg.screen_addr;
         1:       a = ledger.cfg.key_low;
         2:       a = ledger.cfg.key_high;
         3:       a = ledger.cfg.key_low - 16'd1;
         4:       a = ledger.cfg.key_high + 16'd1;
         default: a = 16'($urandom);
      endcase
      send_byte(ledger.cfg.first_start);
      send_byte(ledger.cfg.second_start);
      send_byte(len[7:0]);
      if (len == 0 || len >= PAYLOAD_MAX) return;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i == 1) b = a[15:8];
         if (i == 2) b = a[7:0];
         send_byte(b);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      if ($urandom_range(1) == 0) send_byte(ledger.cfg.first_start);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
   endtask

   initial begin
      int target;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      src_idle       = 33;
      sink_idle      = 84;
      bytes_sent     = 0;
      settings_used  = 0;
      ledger         = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_seq[i]) send_byte(directed_seq[i]);

      for (int p = 0; p < 6; p++) begin
         settle();
         apply_cfg(make_cfg(p));
         if (p < 2) begin
            src_idle  = 33;
            sink_idle = 84;
         end else if (p < 4) begin
            src_idle  = 84;
            sink_idle = 33;
         end else begin
            src_idle  = 0;
            sink_idle = 0;
         end
         target = bytes_sent + 215;
         while (bytes_sent < target) begin
            if ($urandom_range(99) < 80) send_frame();
            else send_noise();
         end
      end
      settle();

      $display("run covered %0d bytes over %0d register settings, %0d frames checked",
               bytes_sent, settings_used, ledger.matched);
      if (ledger.errors == 0) begin
         $display("[touch_frame_parser_core] OK");
      end else begin
         $display("[touch_frame_parser_core] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[touch_frame_parser_core] ERROR");
      $finish;
   end

endmodule
